// ----- hdl/ghalloc_pkg.sv -----
// package: widths, codes and slot entry layout of the generational handle allocator
`default_nettype none

package ghalloc_pkg;

  localparam int INDEX_BITS  = 8;
  localparam int GEN_BITS    = 8;
  localparam int REF_BITS    = 32;
  localparam int HANDLE_BITS = INDEX_BITS + GEN_BITS;
  localparam int NUM_SLOTS   = 1 << INDEX_BITS;
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 2;

  localparam int IN_BITS    = CMD_BITS + HANDLE_BITS + REF_BITS;
  localparam int OUT_BITS   = STATUS_BITS + HANDLE_BITS + REF_BITS;
  localparam int IN_TDATA   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_LIVE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [GEN_BITS-1:0]   gen;
    logic [INDEX_BITS-1:0] free_link;
    logic                  live;
    logic [REF_BITS-1:0]   entity;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

`default_nettype wire

// ----- hdl/generational_handle_allocator.sv -----
// top level: slot table handing out generation-checked handles
//
// channel  dir  width  fields (low bit up)
// s_axis   in   56     cmd[1:0], handle[17:2], entity_ref[49:18], zero pad
// m_axis   out  56     status[1:0], out_handle[17:2], out_entity_ref[49:18], zero pad
//
// path from accept to result: input register, table read, result register
// one item per cycle unless m_axis stalls; the ram read and free-head update form the loop
// a write back in the same cycle as the next read is forwarded from a bypass register
// reset empties the free list and the used count; the table ram needs no clearing pass
// a stalled result holds the pipe; bubbles ahead of it still fill
`default_nettype none

module generational_handle_allocator
  import ghalloc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [IN_TDATA-1:0]  s_axis_tdata_i,   // cmd, handle, entity_ref
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [OUT_TDATA-1:0] m_axis_tdata_o    // status, out_handle, out_entity_ref
);

  // pipeline registers
  logic                   s1_v_q;
  cmd_e                   s1_cmd_q;
  logic [HANDLE_BITS-1:0] s1_handle_q;
  logic [REF_BITS-1:0]    s1_ent_q;

  logic                   s2_v_q;
  cmd_e                   s2_cmd_q;
  logic [HANDLE_BITS-1:0] s2_handle_q;
  logic [REF_BITS-1:0]    s2_ent_q;

  logic                   out_v_q;
  status_e                out_status_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [REF_BITS-1:0]    out_ent_q;

  logic [INDEX_BITS:0]    free_head_q, free_head_d;
  logic [INDEX_BITS:0]    used_q, used_d;

  logic                   byp_q;
  entry_t                 byp_data_q;

  logic                   out_en, s2_fire, s1_adv, in_acc;
  logic [INDEX_BITS-1:0]  raddr;
  logic [ENTRY_BITS-1:0]  rdata;
  entry_t                 ent;

  logic                   we;
  logic [INDEX_BITS-1:0]  waddr;
  entry_t                 wdata;
  status_e                res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [REF_BITS-1:0]    res_ent;

  logic [INDEX_BITS-1:0]  h_slot;
  logic [GEN_BITS-1:0]    h_gen;
  logic [INDEX_BITS-1:0]  fh_slot;
  logic [GEN_BITS-1:0]    gen_inc;
  logic                   fh_empty, table_full, h_live;

  assign out_en  = !out_v_q || m_axis_tready_i;
  assign s2_fire = s2_v_q && out_en;
  assign s1_adv  = s1_v_q && (!s2_v_q || out_en);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !s1_v_q || !s2_v_q || out_en;

  assign raddr = (s1_cmd_q == CMD_ADD) ? free_head_d[INDEX_BITS-1:0]
                                       : s1_handle_q[INDEX_BITS-1:0];

  ghalloc_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (s1_adv),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent = byp_q ? byp_data_q : entry_t'(rdata);

  assign h_slot     = s2_handle_q[INDEX_BITS-1:0];
  assign h_gen      = s2_handle_q[HANDLE_BITS-1:INDEX_BITS];
  assign fh_slot    = free_head_q[INDEX_BITS-1:0];
  assign fh_empty   = free_head_q[INDEX_BITS];
  assign table_full = used_q[INDEX_BITS];
  assign gen_inc    = ent.gen + GEN_BITS'(1);
  assign h_live     = ({1'b0, h_slot} < used_q) && (ent.gen == h_gen) && ent.live;

  // result and table update of the item in the read stage
  always_comb begin
    we          = 1'b0;
    waddr       = h_slot;
    wdata       = ent;
    res_status  = ST_NOT_LIVE;
    res_handle  = s2_handle_q;
    res_ent     = '0;
    free_head_d = free_head_q;
    used_d      = used_q;
    unique case (s2_cmd_q)
      CMD_ADD: begin
        if (!fh_empty) begin
          we               = s2_fire;
          waddr            = fh_slot;
          wdata.gen        = gen_inc;
          wdata.live       = 1'b1;
          wdata.entity     = s2_ent_q;
          res_status       = ST_OK;
          res_handle       = {gen_inc, fh_slot};
          if (s2_fire) begin
            free_head_d = (ent.free_link == fh_slot) ? (INDEX_BITS+1)'(NUM_SLOTS)
                                                     : {1'b0, ent.free_link};
          end
        end else if (!table_full) begin
          we               = s2_fire;
          waddr            = used_q[INDEX_BITS-1:0];
          wdata.gen        = '0;
          wdata.free_link  = used_q[INDEX_BITS-1:0];
          wdata.live       = 1'b1;
          wdata.entity     = s2_ent_q;
          res_status       = ST_OK;
          res_handle       = {{GEN_BITS{1'b0}}, used_q[INDEX_BITS-1:0]};
          if (s2_fire) begin
            used_d = used_q + (INDEX_BITS+1)'(1);
          end
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (h_live) begin
          we              = s2_fire;
          wdata.free_link = fh_empty ? h_slot : fh_slot;
          wdata.live      = 1'b0;
          res_status      = ST_OK;
          if (s2_fire) begin
            free_head_d = {1'b0, h_slot};
          end
        end
      end
      default: begin
        if (h_live) begin
          res_status = ST_OK;
          res_ent    = ent.entity;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      byp_q       <= 1'b0;
      free_head_q <= (INDEX_BITS+1)'(NUM_SLOTS);
      used_q      <= '0;
    end else begin
      free_head_q <= free_head_d;
      used_q      <= used_d;
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
        byp_q  <= we && (waddr == raddr);
      end else if (s2_fire) begin
        s2_v_q <= 1'b0;
      end
      if (s2_fire) begin
        out_v_q <= 1'b1;
      end else if (out_en) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q    <= cmd_e'(s_axis_tdata_i[CMD_BITS-1:0]);
      s1_handle_q <= s_axis_tdata_i[CMD_BITS +: HANDLE_BITS];
      s1_ent_q    <= s_axis_tdata_i[CMD_BITS+HANDLE_BITS +: REF_BITS];
    end
    if (s1_adv) begin
      s2_cmd_q    <= s1_cmd_q;
      s2_handle_q <= s1_handle_q;
      s2_ent_q    <= s1_ent_q;
      byp_data_q  <= wdata;
    end
    if (s2_fire) begin
      out_status_q <= res_status;
      out_handle_q <= res_handle;
      out_ent_q    <= res_ent;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA-OUT_BITS){1'b0}}, out_ent_q, out_handle_q, out_status_q};

endmodule

`default_nettype wire

// ----- hdl/ghalloc_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module ghalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
